[hw/rtl/rkf_pkg.sv]
// Shared types and command codes for the recent-key filter.
package rkf_pkg;

    localparam int KEY_W        = 64;
    localparam int FILL_LEVEL_W = 7;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [KEY_W-1:0] key;
    } req_item_t;

    typedef struct packed {
        logic                    found;
        logic                    evicted;
        logic [KEY_W-1:0]        evicted_key;
        logic [FILL_LEVEL_W-1:0] fill_level;
    } rsp_item_t;

endpackage

[hw/rtl/rkf_cell.sv]
// One key cell of the shift/rotate chain.
module rkf_cell #(
    parameter int KEY_BITS = 64
) (
    input  logic                clk,
    input  logic                shift,
    input  logic [KEY_BITS-1:0] key_in,
    output logic [KEY_BITS-1:0] key
);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;

    // take the left neighbor's key on a shift, hold otherwise
    assign key_next = shift ? key_in : key_reg;

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key = key_reg;

endmodule

[hw/rtl/recent_key_filter_fifo_evict.sv]
// Top level: recent-key filter with FIFO eviction, built on a rotating chain of key cells.
// Lookup/insert: accepted in idle, the chain then rotates once in the scan state and the result
// register loads in the finish state; clear skips the scan. No new item is taken until the last
// one finishes, as the chain rotates past the single comparator at its tail; a waiting result
// holds the finish. Reset (rst_n low, async): control and fill count go to zero; cell keys are
// not cleared, since only cells below the fill count are ever compared.
module recent_key_filter_fifo_evict #(
    parameter int DEPTH    = 64,
    parameter int KEY_BITS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  rkf_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rkf_pkg::rsp_item_t rsp
);

    localparam int FILL_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Cell j holds the j-th newest key; cells at or above the fill count are stale.
    // An insert shifts the new key in at cell 0, so a full chain drops its oldest
    // key out of the tail. A search rotates the whole chain once (tail back to
    // cell 0) and compares the key leaving the tail each cycle.

    state_t               state_reg;
    logic [FILL_W-1:0]    step_reg;
    logic [FILL_W-1:0]    fill_reg;
    logic                 hit_reg;
    logic [1:0]           cmd_reg;
    logic [KEY_BITS-1:0]  qkey_reg;
    logic                 rsp_valid_reg;
    rkf_pkg::rsp_item_t   rsp_reg;

    logic [KEY_BITS-1:0]  cell_key [DEPTH];
    logic [KEY_BITS-1:0]  tail_key;
    logic [KEY_BITS-1:0]  head_key;
    logic                 shift_en;

    logic                 req_xfer;
    logic                 rsp_free;
    logic                 finish_go;
    logic                 do_insert;
    logic                 full;
    logic [FILL_W:0]      scan_sum;
    logic                 slot_live;
    logic                 tail_match;
    logic                 scan_last;
    logic [FILL_W-1:0]    fill_next;
    logic [FILL_W+6:0]    fill_wide;
    rkf_pkg::rsp_item_t   rsp_next;

    // ---------------------------------------------------------------
    // Cell chain
    // ---------------------------------------------------------------
    assign tail_key = cell_key[DEPTH-1];
    // rotate during a scan, otherwise feed the inserted key
    assign head_key = (state_reg == ST_SCAN) ? tail_key : qkey_reg;
    assign shift_en = (state_reg == ST_SCAN) || do_insert;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                rkf_cell #(
                    .KEY_BITS(KEY_BITS)
                ) u_cell (
                    .clk    (clk),
                    .shift  (shift_en),
                    .key_in (head_key),
                    .key    (cell_key[gi])
                );
            end
            else
            begin : g_body
                rkf_cell #(
                    .KEY_BITS(KEY_BITS)
                ) u_cell (
                    .clk    (clk),
                    .shift  (shift_en),
                    .key_in (cell_key[gi-1]),
                    .key    (cell_key[gi])
                );
            end
        end
    endgenerate

    // ---------------------------------------------------------------
    // Scan compare: at step t the tail holds original cell DEPTH-1-t,
    // which is live when t + fill >= DEPTH.
    // ---------------------------------------------------------------
    assign scan_sum   = {1'b0, fill_reg} + {1'b0, step_reg};
    assign slot_live  = scan_sum >= (FILL_W + 1)'(DEPTH);
    assign tail_match = slot_live && (tail_key == qkey_reg);
    assign scan_last  = step_reg == FILL_W'(DEPTH - 1);

    // ---------------------------------------------------------------
    // Finish: result goes out, insert shifts in (evicting on full)
    // ---------------------------------------------------------------
    assign req_stall = state_reg != ST_IDLE;
    assign req_xfer  = req_valid && !req_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign finish_go = (state_reg == ST_FINISH) && rsp_free;
    assign do_insert = finish_go && (cmd_reg == rkf_pkg::CMD_INSERT) && !hit_reg;
    assign full      = fill_reg == FILL_W'(DEPTH);

    always_comb
    begin
        if (cmd_reg == rkf_pkg::CMD_CLEAR)
        begin
            fill_next = '0;
        end
        else if (do_insert && !full)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else
        begin
            fill_next = fill_reg;
        end
    end

    assign fill_wide = {7'd0, fill_next};

    always_comb
    begin
        rsp_next             = '0;
        rsp_next.found       = (cmd_reg != rkf_pkg::CMD_CLEAR) && hit_reg;
        rsp_next.evicted     = do_insert && full;
        if (do_insert && full)
        begin
            rsp_next.evicted_key[KEY_BITS-1:0] = tail_key;
        end
        rsp_next.fill_level  = fill_wide[6:0];
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            fill_reg      <= '0;
            hit_reg       <= 1'b0;
            cmd_reg       <= rkf_pkg::CMD_LOOKUP;
            qkey_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            // a finishing item reloads the result register in the same cycle
            if (rsp_valid_reg && !rsp_stall && !finish_go)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (req_xfer)
                    begin
                        cmd_reg  <= req.cmd;
                        qkey_reg <= req.key[KEY_BITS-1:0];
                        hit_reg  <= 1'b0;
                        step_reg <= '0;
                        // clear needs no scan
                        state_reg <= (req.cmd == rkf_pkg::CMD_CLEAR) ? ST_FINISH : ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (tail_match)
                    begin
                        hit_reg <= 1'b1;
                    end
                    if (scan_last)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_FINISH:
                begin
                    if (finish_go)
                    begin
                        fill_reg      <= fill_next;
                        rsp_reg       <= rsp_next;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(DEPTH))
        else $error("fill count above depth");

    a_evict_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.evicted) |-> !rsp.found)
        else $error("eviction reported on a key that was found");

    a_evict_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.evicted) |-> (rsp.evicted_key == '0))
        else $error("evicted key nonzero without eviction");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (finish_go && cmd_reg == rkf_pkg::CMD_CLEAR) |=> (fill_reg == '0))
        else $error("clear left entries in the store");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && scan_last) |=> (state_reg == ST_FINISH))
        else $error("scan did not end after a full rotation");
`endif

endmodule

[tb/tb_recent_key_filter_fifo_evict.sv]
// Self-checking testbench for the recent-key filter with oldest-first eviction.
`timescale 1ns / 1ps

module tb_recent_key_filter_fifo_evict;

    localparam int DEPTH    = 64;
    localparam int KEY_BITS = 64;

    // cmd 3 is not a defined operation; the block treats it as a lookup
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int DIR_ROWS    = 20;
    localparam int RAND_ITEMS  = 1350;
    localparam int HOLD_CYCLES = 600;     // length of the receiver hold-off
    localparam int HISTORY_MAX = 160;     // recently inserted keys kept for reuse
    localparam int CYCLE_LIMIT = 3000000;

    // One row of the directed table. When has_rsp is set the expected
    // result is typed in here; otherwise it comes from the predictor.
    typedef struct packed {
        logic [1:0]                       cmd;
        logic [rkf_pkg::KEY_W-1:0]        key;
        logic                             has_rsp;
        logic                             found;
        logic                             evicted;
        logic [rkf_pkg::KEY_W-1:0]        evicted_key;
        logic [rkf_pkg::FILL_LEVEL_W-1:0] fill_level;
    } dir_row_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    rkf_pkg::req_item_t req       = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    rkf_pkg::rsp_item_t rsp;

    // Predictor state: the keys held, how many, and the next one to go
    logic [KEY_BITS-1:0] held_keys [DEPTH];
    int                  held_count = 0;
    int                  oldest_slot = 0;

    rkf_pkg::rsp_item_t        pending_rsp_q [$];   // expected results, oldest first
    logic [rkf_pkg::KEY_W-1:0] recent_keys [$];     // inserted keys, for hits and misses
    rkf_pkg::rsp_item_t        want_rsp;
    int                        items_sent  = 0;
    int                        error_count = 0;
    int                        cycle_count = 0;
    bit                        hold_rsp_req = 1'b0; // asks the receiver for one long hold-off
    bit                        no_idle      = 1'b0; // gapless stretch on the sender side

    // Extremes first, then the special cases: duplicate inserts, the unused
    // command, clear with a nonzero key, and stale slots after a clear that
    // must not be compared.
    dir_row_t dir_tab [0:DIR_ROWS-1] = '{
        '{rkf_pkg::CMD_LOOKUP, 64'h0000_0000_0000_0000, 1'b1, 1'b0, 1'b0, 64'h0, 7'd0},
        '{rkf_pkg::CMD_INSERT, 64'h0000_0000_0000_0000, 1'b1, 1'b0, 1'b0, 64'h0, 7'd1},
        '{rkf_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 64'h0, 7'd2},
        '{rkf_pkg::CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0, 64'h0, 7'd2},
        '{rkf_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0, 64'h0, 7'd2},
        '{rkf_pkg::CMD_INSERT, 64'h0000_0000_0000_0000, 1'b1, 1'b1, 1'b0, 64'h0, 7'd2},
        '{CMD_UNUSED,          64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0, 64'h0, 7'd2},
        '{CMD_UNUSED,          64'h0000_0000_0000_0005, 1'b1, 1'b0, 1'b0, 64'h0, 7'd2},
        '{rkf_pkg::CMD_LOOKUP, 64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b0, 64'h0, 7'd2},
        '{rkf_pkg::CMD_INSERT, 64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b0, 64'h0, 7'd3},
        '{rkf_pkg::CMD_INSERT, 64'h0000_0000_0000_0001, 1'b1, 1'b0, 1'b0, 64'h0, 7'd4},
        '{rkf_pkg::CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 1'b0, 64'h0, 7'd0},
        '{rkf_pkg::CMD_INSERT, 64'h5555_5555_5555_5555, 1'b0, 1'b0, 1'b0, 64'h0, 7'd0},
        '{rkf_pkg::CMD_LOOKUP, 64'h5555_5555_5555_5555, 1'b0, 1'b0, 1'b0, 64'h0, 7'd0},
        '{rkf_pkg::CMD_CLEAR,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 64'h0, 7'd0},
        '{rkf_pkg::CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 64'h0, 7'd0},
        '{rkf_pkg::CMD_LOOKUP, 64'h0000_0000_0000_0000, 1'b1, 1'b0, 1'b0, 64'h0, 7'd0},
        '{rkf_pkg::CMD_INSERT, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 1'b0, 64'h0, 7'd0},
        '{rkf_pkg::CMD_CLEAR,  64'h0000_0000_0000_0000, 1'b1, 1'b0, 1'b0, 64'h0, 7'd0},
        '{CMD_UNUSED,          64'h0000_0000_0000_0000, 1'b1, 1'b0, 1'b0, 64'h0, 7'd0}
    };

    recent_key_filter_fifo_evict #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Applies one command to the predicted store and returns its result.
    // Only slots below the fill count are compared; a full store overwrites
    // the oldest slot and the pointer wraps at DEPTH.
    function automatic rkf_pkg::rsp_item_t predict_filter(input rkf_pkg::req_item_t item);
        rkf_pkg::rsp_item_t  res;
        logic [KEY_BITS-1:0] k;
        bit                  hit;
        res = '0;
        k   = item.key[KEY_BITS-1:0];
        hit = 1'b0;
        if (item.cmd == rkf_pkg::CMD_CLEAR)
        begin
            held_count  = 0;
            oldest_slot = 0;
        end
        else
        begin
            for (int i = 0; i < held_count; i++)
                if (held_keys[i] == k)
                    hit = 1'b1;
            if (item.cmd == rkf_pkg::CMD_INSERT && !hit)
            begin
                if (held_count >= DEPTH)
                begin
                    res.evicted                     = 1'b1;
                    res.evicted_key[KEY_BITS-1:0]   = held_keys[oldest_slot];
                    held_keys[oldest_slot]          = k;
                    oldest_slot                     = (oldest_slot + 1) % DEPTH;
                end
                else
                begin
                    held_keys[held_count] = k;
                    held_count++;
                end
            end
        end
        res.found      = hit;
        res.fill_level = held_count[rkf_pkg::FILL_LEVEL_W-1:0];
        return res;
    endfunction

    // Idle length between transfers: mostly none or short, now and then
    // long enough to land anywhere in an item's rotation.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 6);
        else if (roll < 97)
            return $urandom_range(7, 70);
        return $urandom_range(71, 200);
    endfunction

    // Key source: fresh_pct percent new values (a few tiny or near
    // all-ones), the rest reused from recent inserts to hit held keys and
    // keys that were evicted since.
    function automatic logic [rkf_pkg::KEY_W-1:0] pick_key(input int fresh_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return rkf_pkg::KEY_W'($urandom_range(0, 15));
        if (roll < 6)
            return ~rkf_pkg::KEY_W'($urandom_range(0, 3));
        if (roll < fresh_pct || recent_keys.size() == 0)
            return {$urandom, $urandom};
        return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    endfunction

    // Offers one item from the falling edge, waits for the transfer, records
    // the expectation at the accepting edge, then idles for the requested gap.
    task automatic send_item(input rkf_pkg::req_item_t item, input int gap,
                             input bit has_rsp, input rkf_pkg::rsp_item_t typed_rsp);
        rkf_pkg::rsp_item_t predicted;
        rkf_pkg::req_item_t idle_req;
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = predict_filter(item);
        if (has_rsp)
            predicted = typed_rsp;
        pending_rsp_q = {pending_rsp_q, predicted};
        if (item.cmd == rkf_pkg::CMD_INSERT)
        begin
            recent_keys = {recent_keys, item.key};
            if (recent_keys.size() > HISTORY_MAX)
                void'(recent_keys.pop_front());
        end
        items_sent++;
        if (gap > 0)
        begin
            // payload is don't-care while idle
            idle_req.cmd = 2'($urandom);
            idle_req.key = {$urandom, $urandom};
            @(negedge clk);
            req_valid <= 1'b0;
            req       <= idle_req;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    // Stimulus: directed table, then random episodes
    initial
    begin
        rkf_pkg::req_item_t item;
        rkf_pkg::rsp_item_t row_rsp;
        int                 kind;
        int                 len;
        int                 roll;
        bit                 held_off;
        bit                 drained;
        held_off = 1'b0;
        drained  = 1'b0;

        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
        begin
            item.cmd               = dir_tab[i].cmd;
            item.key               = dir_tab[i].key;
            row_rsp.found          = dir_tab[i].found;
            row_rsp.evicted        = dir_tab[i].evicted;
            row_rsp.evicted_key    = dir_tab[i].evicted_key;
            row_rsp.fill_level     = dir_tab[i].fill_level;
            send_item(item, pick_gap(), dir_tab[i].has_rsp, row_rsp);
        end

        while (items_sent < DIR_ROWS + RAND_ITEMS)
        begin
            no_idle = ($urandom_range(0, 3) == 0);

            // Receiver hold-off with the sender pushing back-to-back: the
            // result register fills, the block holds in finish and req_stall stays up.
            if (!held_off && items_sent >= 300)
            begin
                held_off     = 1'b1;
                hold_rsp_req = 1'b1;
                repeat (14)
                begin
                    item.cmd = rkf_pkg::CMD_INSERT;
                    item.key = pick_key(70);
                    send_item(item, 0, 1'b0, '0);
                end
            end

            // Sender pause until every result is back
            if (!drained && items_sent >= 800)
            begin
                drained = 1'b1;
                @(negedge clk);
                req_valid <= 1'b0;
                while (pending_rsp_q.size() != 0)
                    @(posedge clk);
            end

            kind = $urandom_range(0, 99);
            if (kind < 40)
            begin
                // insert run, at times long enough to wrap the store and evict
                len = $urandom_range(20, 90);
                repeat (len)
                begin
                    item.cmd = rkf_pkg::CMD_INSERT;
                    item.key = pick_key(80);
                    send_item(item, pick_gap(), 1'b0, '0);
                end
            end
            else if (kind < 70)
            begin
                len = $urandom_range(5, 30);
                repeat (len)
                begin
                    item.cmd = rkf_pkg::CMD_LOOKUP;
                    item.key = pick_key(30);
                    send_item(item, pick_gap(), 1'b0, '0);
                end
            end
            else if (kind < 94)
            begin
                // noise: every code including the unused one, rare clears
                len = $urandom_range(5, 25);
                repeat (len)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 45)
                        item.cmd = rkf_pkg::CMD_INSERT;
                    else if (roll < 88)
                        item.cmd = rkf_pkg::CMD_LOOKUP;
                    else if (roll < 97)
                        item.cmd = CMD_UNUSED;
                    else
                        item.cmd = rkf_pkg::CMD_CLEAR;
                    item.key = pick_key(50);
                    send_item(item, pick_gap(), 1'b0, '0);
                end
            end
            else
            begin
                // clear, sometimes on an idle block
                if ($urandom_range(0, 1) == 1)
                begin
                    @(negedge clk);
                    req_valid <= 1'b0;
                    while (pending_rsp_q.size() != 0)
                        @(posedge clk);
                end
                item.cmd = rkf_pkg::CMD_CLEAR;
                item.key = {$urandom, $urandom};
                send_item(item, pick_gap(), 1'b0, '0);
            end
        end

        @(negedge clk);
        req_valid <= 1'b0;

        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        // catch any stray result
        repeat (DEPTH + 8)
            @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver back-pressure: runs of free flow, random stalls, or one
    // solid stall; plus the single long hold-off asked for by the sender.
    initial
    begin
        int mode;
        int len;
        @(posedge rst_n);
        forever
        begin
            if (hold_rsp_req)
            begin
                @(negedge clk);
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
                rsp_stall    <= 1'b0;
                hold_rsp_req = 1'b0;
            end
            else
            begin
                mode = $urandom_range(0, 99);
                len  = $urandom_range(1, 40);
                if (mode >= 90)
                    len = $urandom_range(20, 150);
                repeat (len)
                begin
                    @(negedge clk);
                    if (mode < 30)
                        rsp_stall <= 1'b0;
                    else if (mode < 90)
                        rsp_stall <= ($urandom_range(0, 99) < 30);
                    else
                        rsp_stall <= 1'b1;
                end
            end
        end
    end

    // Result checker: each transfer against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp_q.size() == 0)
            begin
                $error("result transfer with no expectation pending");
                error_count++;
            end
            else
            begin
                want_rsp = pending_rsp_q.pop_front();
                if (rsp.found !== want_rsp.found)
                begin
                    $error("found: expected %0d, actual %0d", want_rsp.found, rsp.found);
                    error_count++;
                end
                if (rsp.evicted !== want_rsp.evicted)
                begin
                    $error("evicted: expected %0d, actual %0d",
                           want_rsp.evicted, rsp.evicted);
                    error_count++;
                end
                if (rsp.evicted_key !== want_rsp.evicted_key)
                begin
                    $error("evicted_key: expected %h, actual %h",
                           want_rsp.evicted_key, rsp.evicted_key);
                    error_count++;
                end
                if (rsp.fill_level !== want_rsp.fill_level)
                begin
                    $error("fill_level: expected %0d, actual %0d",
                           want_rsp.fill_level, rsp.fill_level);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

[files.f]
hw/rtl/rkf_pkg.sv
hw/rtl/rkf_cell.sv
hw/rtl/recent_key_filter_fifo_evict.sv
tb/tb_recent_key_filter_fifo_evict.sv
